FILE: hw/rtl/rfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response frame checker package
// Shared constants, types and the byte-wide CRC-16 step.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam int unsigned POS_W      = 17;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned CMD_POS_DEF  = 3;
  localparam int unsigned STAT_POS_DEF = 6;

  localparam logic [7:0]       ACK_BYTE  = 8'h06;
  localparam logic [7:0]       NAK_BYTE  = 8'h15;
  localparam logic [7:0]       ERR_MARK  = 8'h4E;
  localparam logic [POS_W-1:0] MIN_FRAME = 17'd8;
  localparam logic [POS_W-1:0] LEN_EXTRA = 17'd5;
  localparam logic [POS_W-1:0] LEN_BODY  = 17'd3;

  localparam logic [CRC_W-1:0] CRC_POLY_RST = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT_RST = 16'h0000;

  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_A    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_B    = 2'd3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NAK      = 3'd1,
    ST_ZERO_LEN = 3'd2,
    ST_SHORT    = 3'd3,
    ST_CMD_BAD  = 3'd4,
    ST_CRC_BAD  = 3'd5,
    ST_DEV_ERR  = 3'd6
  } status_e;

  typedef struct packed {
    logic [CRC_W-1:0] crc_poly;
    logic [CRC_W-1:0] crc_init;
    logic [7:0]       cmd_a;
    logic [7:0]       cmd_b;
  } cfg_t;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] frame_len;
    logic [7:0]       dev_hi;
    logic [7:0]       dev_lo;
  } result_t;

  function automatic logic [CRC_W-1:0] crc_byte(logic [CRC_W-1:0] crc,
                                                logic [7:0] data,
                                                logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] c;
    logic [7:0]       d;
    c = crc;
    d = data;
    for (int i = 0; i < 8; i++) begin
      if (d[7] ^ c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
      d = {d[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/rfc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the CRC polynomial, CRC start value and expected command echo bytes.
// ----------------------------------------------------------------------------
module rfc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rfc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output rfc_pkg::cfg_t                    cfg_o
);

  rfc_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_poly <= rfc_pkg::CRC_POLY_RST;
      cfg_q.crc_init <= rfc_pkg::CRC_INIT_RST;
      cfg_q.cmd_a    <= 8'h00;
      cfg_q.cmd_b    <= 8'h00;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rfc_pkg::CFG_CRC_POLY: cfg_q.crc_poly <= cfg_data_i;
        rfc_pkg::CFG_CRC_INIT: cfg_q.crc_init <= cfg_data_i;
        rfc_pkg::CFG_CMD_A:    cfg_q.cmd_a    <= cfg_data_i[7:0];
        rfc_pkg::CFG_CMD_B:    cfg_q.cmd_b    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/rfc_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser
// Tracks the byte position, length, CRC and echo checks of one reply frame
// and forms the result on the last byte, or on a NAK byte in the first position.
// ----------------------------------------------------------------------------
module rfc_frame_parser #(
  parameter int unsigned CMD_POS  = rfc_pkg::CMD_POS_DEF,
  parameter int unsigned STAT_POS = rfc_pkg::STAT_POS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             frame_start_i,
  input  rfc_pkg::cfg_t    cfg_i,
  output logic             res_valid_o,
  output rfc_pkg::result_t res_o
);

  localparam logic [rfc_pkg::POS_W-1:0] P_CMD   = rfc_pkg::POS_W'(CMD_POS);
  localparam logic [rfc_pkg::POS_W-1:0] P_CMD_A = rfc_pkg::POS_W'(CMD_POS + 1);
  localparam logic [rfc_pkg::POS_W-1:0] P_CMD_B = rfc_pkg::POS_W'(CMD_POS + 2);
  localparam logic [rfc_pkg::POS_W-1:0] P_ST_HI = rfc_pkg::POS_W'(STAT_POS);
  localparam logic [rfc_pkg::POS_W-1:0] P_ST_LO = rfc_pkg::POS_W'(STAT_POS + 1);
  localparam logic [rfc_pkg::POS_W-1:0] P_HDR   = 17'd3;

  logic [rfc_pkg::POS_W-1:0] pos_q, pos_d;
  logic [rfc_pkg::LEN_W-1:0] len_q, len_d;
  logic [rfc_pkg::CRC_W-1:0] crc_q, crc_d;
  logic [7:0]                crc_hi_q, crc_hi_d;
  logic                      cmd_bad_q, cmd_bad_d;
  logic                      neg_q, neg_d;
  logic [7:0]                code_hi_q, code_hi_d;
  logic [7:0]                code_lo_q, code_lo_d;

  logic [rfc_pkg::POS_W-1:0] pos;
  logic [rfc_pkg::POS_W-1:0] total;
  logic [rfc_pkg::CRC_W-1:0] crc_base;
  logic [rfc_pkg::CRC_W-1:0] crc_step;
  logic                      cmd_bad_f;
  logic                      crc_ok;
  rfc_pkg::status_e          status;

  always_comb begin
    pos         = frame_start_i ? '0 : pos_q;
    pos_d       = pos_q;
    len_d       = len_q;
    crc_d       = crc_q;
    crc_hi_d    = crc_hi_q;
    cmd_bad_d   = cmd_bad_q;
    neg_d       = neg_q;
    code_hi_d   = code_hi_q;
    code_lo_d   = code_lo_q;
    crc_base    = crc_q;
    total       = '0;
    crc_step    = '0;
    cmd_bad_f   = 1'b0;
    crc_ok      = 1'b0;
    status      = rfc_pkg::ST_OK;
    res_valid_o = 1'b0;
    res_o       = '{status: rfc_pkg::ST_NAK, frame_len: '0, dev_hi: 8'h00, dev_lo: 8'h00};

    if (en_i) begin
      if (pos == '0 && rx_byte_i == rfc_pkg::ACK_BYTE) begin
        pos_d = '0;
      end else if (pos == '0 && rx_byte_i == rfc_pkg::NAK_BYTE) begin
        pos_d       = '0;
        res_valid_o = 1'b1;
      end else begin
        if (pos == '0) begin
          crc_base  = cfg_i.crc_init;
          len_d     = '0;
          crc_hi_d  = 8'h00;
          cmd_bad_d = 1'b0;
          neg_d     = 1'b0;
          code_hi_d = 8'h00;
          code_lo_d = 8'h00;
        end
        if (pos == 17'd1) begin
          len_d = {rx_byte_i, 8'h00};
        end else if (pos == 17'd2) begin
          len_d = len_d | {8'h00, rx_byte_i};
        end
        if (pos == P_CMD) begin
          neg_d = (rx_byte_i == rfc_pkg::ERR_MARK);
        end
        if (pos == P_CMD_A && rx_byte_i != cfg_i.cmd_a) begin
          cmd_bad_d = 1'b1;
        end
        if (pos == P_CMD_B && rx_byte_i != cfg_i.cmd_b) begin
          cmd_bad_d = 1'b1;
        end
        if (pos == P_ST_HI) begin
          code_hi_d = rx_byte_i;
        end
        if (pos == P_ST_LO) begin
          code_lo_d = rx_byte_i;
        end

        crc_step = rfc_pkg::crc_byte(crc_base, rx_byte_i, cfg_i.crc_poly);
        total    = {1'b0, len_d} + rfc_pkg::LEN_EXTRA;

        if (pos < P_HDR || pos < total - 17'd2) begin
          crc_d = crc_step;
          pos_d = pos + 17'd1;
        end else if (pos == total - 17'd2) begin
          crc_d    = crc_base;
          crc_hi_d = rx_byte_i;
          pos_d    = pos + 17'd1;
        end else begin
          crc_d     = crc_base;
          cmd_bad_f = cmd_bad_d
                    | (P_CMD_A >= total && cfg_i.cmd_a != 8'h00)
                    | (P_CMD_B >= total && cfg_i.cmd_b != 8'h00);
          cmd_bad_d = cmd_bad_f;
          crc_ok    = ({crc_hi_d, rx_byte_i} == crc_base);
          if (len_d == '0) begin
            status = rfc_pkg::ST_ZERO_LEN;
          end else if (total < rfc_pkg::MIN_FRAME) begin
            status = rfc_pkg::ST_SHORT;
          end else if (cmd_bad_f) begin
            status = rfc_pkg::ST_CMD_BAD;
          end else if (!crc_ok) begin
            status = rfc_pkg::ST_CRC_BAD;
          end else if (neg_d) begin
            status = rfc_pkg::ST_DEV_ERR;
          end else begin
            status = rfc_pkg::ST_OK;
          end
          res_valid_o     = 1'b1;
          res_o.status    = status;
          res_o.frame_len = {1'b0, len_d} + rfc_pkg::LEN_BODY;
          res_o.dev_hi    = (status == rfc_pkg::ST_DEV_ERR) ? code_hi_d : 8'h00;
          res_o.dev_lo    = (status == rfc_pkg::ST_DEV_ERR) ? code_lo_d : 8'h00;
          pos_d           = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      len_q     <= '0;
      crc_q     <= rfc_pkg::CRC_INIT_RST;
      crc_hi_q  <= 8'h00;
      cmd_bad_q <= 1'b0;
      neg_q     <= 1'b0;
      code_hi_q <= 8'h00;
      code_lo_q <= 8'h00;
    end else begin
      pos_q     <= pos_d;
      len_q     <= len_d;
      crc_q     <= crc_d;
      crc_hi_q  <= crc_hi_d;
      cmd_bad_q <= cmd_bad_d;
      neg_q     <= neg_d;
      code_hi_q <= code_hi_d;
      code_lo_q <= code_lo_d;
    end
  end

endmodule

FILE: hw/rtl/response_frame_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response frame checker
// Checks length-prefixed device reply frames byte by byte and reports one
// status transaction per frame.
// ----------------------------------------------------------------------------
// The last byte of a frame is registered in the input stage, and its result in the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the byte-wide CRC step.
// While a result waits in the output register, the input stage holds and new bytes stall.
// Reset clears the parser frame state and the valid flags and loads the register defaults.
module response_frame_checker_unit #(
  parameter int unsigned CMD_POS  = rfc_pkg::CMD_POS_DEF,
  parameter int unsigned STAT_POS = rfc_pkg::STAT_POS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rfc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           frame_start_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     status_o,
  output logic [rfc_pkg::POS_W-1:0]      frame_len_o,
  output logic [7:0]                     dev_code_hi_o,
  output logic [7:0]                     dev_code_lo_o
);

  rfc_pkg::cfg_t    cfg;
  rfc_pkg::result_t res;
  rfc_pkg::result_t res_q;
  logic             res_valid;

  logic       s1_valid_q;
  logic [7:0] rx_q;
  logic       start_q;
  logic       out_valid_q;
  logic       slot_free;
  logic       proc_en;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign proc_en    = s1_valid_q && slot_free;
  assign in_ready_o = !s1_valid_q || slot_free;

  rfc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rfc_frame_parser #(
    .CMD_POS  (CMD_POS),
    .STAT_POS (STAT_POS)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (proc_en),
    .rx_byte_i     (rx_q),
    .frame_start_i (start_q),
    .cfg_i         (cfg),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rx_q    <= rx_byte_i;
      start_q <= frame_start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= proc_en && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_en && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign frame_len_o   = res_q.frame_len;
  assign dev_code_hi_o = res_q.dev_hi;
  assign dev_code_lo_o = res_q.dev_lo;

  a_nak_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rfc_pkg::ST_NAK |-> frame_len_o == '0)
    else $error("NAK transaction carries a nonzero frame length");

  a_frame_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != rfc_pkg::ST_NAK |-> frame_len_o >= rfc_pkg::LEN_BODY)
    else $error("Frame transaction length is below the header size");

  a_codes_only_on_dev_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != rfc_pkg::ST_DEV_ERR |->
      dev_code_hi_o == 8'h00 && dev_code_lo_o == 8'h00)
    else $error("Device codes are set without a device error");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !proc_en |=> s1_valid_q && $stable(rx_q) && $stable(start_q))
    else $error("Input stage lost a byte while the output was stalled");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_q))
    else $error("Pending result was overwritten before it was taken");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response frame checker testbench
// Sends device reply bytes and checks each status transaction against a
// local predictor. Directed frames cover every status, then register
// extremes, a maximum length header, output backpressure, and random traffic.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CMD_AT       = rfc_pkg::CMD_POS_DEF;
  localparam int unsigned STAT_AT      = rfc_pkg::STAT_POS_DEF;
  localparam int unsigned RANDOM_BYTES = 1080;

  typedef enum int {FR_GOOD, FR_DEV_ERR, FR_CMD_BAD, FR_CRC_BAD} frame_kind_e;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [rfc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rfc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  logic [7:0]                     rx_byte;
  logic                           frame_start;
  logic                           out_valid;
  logic                           out_ready;
  logic [2:0]                     status;
  logic [rfc_pkg::POS_W-1:0]      frame_len;
  logic [7:0]                     dev_hi;
  logic [7:0]                     dev_lo;

  logic [15:0] poly_q;
  logic [15:0] init_q;
  logic [7:0]  cmd_a_q;
  logic [7:0]  cmd_b_q;
  logic [16:0] pos_q;
  logic [15:0] len_q;
  logic [15:0] crc_q;
  logic [7:0]  crc_hi_q;
  logic        echo_bad_q;
  logic        dev_err_q;
  logic [7:0]  code_hi_q;
  logic [7:0]  code_lo_q;

  rfc_pkg::result_t pending_reports[$];
  logic [7:0]       frame_bytes[$];
  int               reply_bytes_sent = 0;
  int               fail_count = 0;
  int               hold_left = 0;
  int               stall_left = 0;
  bit               tx_gaps_on = 1'b1;
  bit               rx_stalls_on = 1'b1;

  always #5 clk = ~clk;

  response_frame_checker_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .rx_byte_i     (rx_byte),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .frame_len_o   (frame_len),
    .dev_code_hi_o (dev_hi),
    .dev_code_lo_o (dev_lo)
  );

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ poly_q) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic void track_reply_byte(input logic [7:0] b, input logic st);
    logic [16:0]      total;
    rfc_pkg::result_t r;
    if (st) begin
      pos_q = '0;
    end
    if (pos_q == 0) begin
      if (b == rfc_pkg::ACK_BYTE) begin
        return;
      end
      if (b == rfc_pkg::NAK_BYTE) begin
        r.status    = rfc_pkg::ST_NAK;
        r.frame_len = '0;
        r.dev_hi    = '0;
        r.dev_lo    = '0;
        pending_reports.push_back(r);
        return;
      end
      crc_q      = init_q;
      len_q      = '0;
      crc_hi_q   = '0;
      echo_bad_q = 1'b0;
      dev_err_q  = 1'b0;
      code_hi_q  = '0;
      code_lo_q  = '0;
    end
    if (pos_q == 1) begin
      len_q = {b, 8'h00};
    end else if (pos_q == 2) begin
      len_q[7:0] = b;
    end
    if (pos_q == CMD_AT) begin
      dev_err_q = (b == rfc_pkg::ERR_MARK);
    end
    if (pos_q == CMD_AT + 1 && b != cmd_a_q) begin
      echo_bad_q = 1'b1;
    end
    if (pos_q == CMD_AT + 2 && b != cmd_b_q) begin
      echo_bad_q = 1'b1;
    end
    if (pos_q == STAT_AT) begin
      code_hi_q = b;
    end
    if (pos_q == STAT_AT + 1) begin
      code_lo_q = b;
    end
    total = {1'b0, len_q} + rfc_pkg::LEN_EXTRA;
    if (pos_q < 3 || pos_q < total - 17'd2) begin
      crc_q = crc16_next(crc_q, b);
      pos_q = pos_q + 17'd1;
      return;
    end
    if (pos_q == total - 17'd2) begin
      crc_hi_q = b;
      pos_q    = pos_q + 17'd1;
      return;
    end
    // Command positions beyond the frame end read as zero bytes.
    if (CMD_AT + 1 >= total && cmd_a_q != 0) begin
      echo_bad_q = 1'b1;
    end
    if (CMD_AT + 2 >= total && cmd_b_q != 0) begin
      echo_bad_q = 1'b1;
    end
    if (len_q == 0) begin
      r.status = rfc_pkg::ST_ZERO_LEN;
    end else if (total < rfc_pkg::MIN_FRAME) begin
      r.status = rfc_pkg::ST_SHORT;
    end else if (echo_bad_q) begin
      r.status = rfc_pkg::ST_CMD_BAD;
    end else if ({crc_hi_q, b} != crc_q) begin
      r.status = rfc_pkg::ST_CRC_BAD;
    end else if (dev_err_q) begin
      r.status = rfc_pkg::ST_DEV_ERR;
    end else begin
      r.status = rfc_pkg::ST_OK;
    end
    r.frame_len = {1'b0, len_q} + rfc_pkg::LEN_BODY;
    r.dev_hi    = (r.status == rfc_pkg::ST_DEV_ERR) ? code_hi_q : 8'h00;
    r.dev_lo    = (r.status == rfc_pkg::ST_DEV_ERR) ? code_lo_q : 8'h00;
    pending_reports.push_back(r);
    pos_q = '0;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end
    if (r < 95) begin
      return $urandom_range(3, 6);
    end
    return $urandom_range(15, 60);
  endfunction

  function automatic void build_body(input logic [15:0] len, input frame_kind_e kind);
    logic [7:0] b;
    int         last;
    frame_bytes.delete();
    do begin
      b = 8'($urandom);
    end while (b == rfc_pkg::ACK_BYTE || b == rfc_pkg::NAK_BYTE);
    frame_bytes.push_back(b);
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(len[7:0]);
    last = int'(len) + 2;
    for (int i = 3; i <= last; i++) begin
      frame_bytes.push_back(8'($urandom));
    end
    if (last >= CMD_AT) begin
      if (kind == FR_DEV_ERR) begin
        frame_bytes[CMD_AT] = rfc_pkg::ERR_MARK;
      end else if (frame_bytes[CMD_AT] == rfc_pkg::ERR_MARK) begin
        frame_bytes[CMD_AT] = ~rfc_pkg::ERR_MARK;
      end
    end
    if (last >= CMD_AT + 1) begin
      frame_bytes[CMD_AT + 1] = cmd_a_q;
    end
    if (last >= CMD_AT + 2) begin
      frame_bytes[CMD_AT + 2] = cmd_b_q;
      if (kind == FR_CMD_BAD) begin
        b = 8'h01 << $urandom_range(0, 7);
        if ($urandom_range(0, 1) == 0) begin
          frame_bytes[CMD_AT + 1] = frame_bytes[CMD_AT + 1] ^ b;
        end else begin
          frame_bytes[CMD_AT + 2] = frame_bytes[CMD_AT + 2] ^ b;
        end
      end
    end
  endfunction

  function automatic void seal_frame(input frame_kind_e kind);
    logic [15:0] c;
    c = init_q;
    foreach (frame_bytes[i]) begin
      c = crc16_next(c, frame_bytes[i]);
    end
    if (kind == FR_CRC_BAD) begin
      c = c ^ (16'h0001 << $urandom_range(0, 15));
    end
    frame_bytes.push_back(c[15:8]);
    frame_bytes.push_back(c[7:0]);
  endfunction

  function automatic void compare_field(input string name, input logic [16:0] exp,
                                        input logic [16:0] act);
    if (exp !== act) begin
      fail_count++;
      if (fail_count <= 40) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic st);
    int gap;
    gap = (tx_gaps_on && $urandom_range(0, 1) == 0) ? draw_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= st;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (!(b == rfc_pkg::ACK_BYTE && (st || pos_q == 0))) begin
      reply_bytes_sent++;
    end
    track_reply_byte(b, st);
  endtask

  task automatic idle_tx();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(input int acks, input logic st);
    for (int i = 0; i < acks; i++) begin
      send_byte(rfc_pkg::ACK_BYTE, st);
      st = 1'b0;
    end
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i], (i == 0) ? st : 1'b0);
    end
  endtask

  task automatic send_new_frame(input logic [15:0] len, input frame_kind_e kind);
    build_body(len, kind);
    seal_frame(kind);
    send_frame(0, 1'b1);
  endtask

  // Closes any partial frame and drains every pending report.
  task automatic settle();
    if (pos_q != 0) begin
      send_byte(rfc_pkg::NAK_BYTE, 1'b1);
    end
    idle_tx();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] poly, input logic [15:0] init,
                              input logic [7:0] a, input logic [7:0] bb);
    logic [rfc_pkg::CFG_IDX_W-1:0] idx [4];
    logic [15:0]                   vals [4];
    settle();
    idx[0]  = rfc_pkg::CFG_CRC_POLY;
    idx[1]  = rfc_pkg::CFG_CRC_INIT;
    idx[2]  = rfc_pkg::CFG_CMD_A;
    idx[3]  = rfc_pkg::CFG_CMD_B;
    vals[0] = poly;
    vals[1] = init;
    vals[2] = {8'h00, a};
    vals[3] = {8'h00, bb};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(negedge clk); while (!cfg_ready);
      @(posedge clk);
      case (idx[i])
        rfc_pkg::CFG_CRC_POLY: poly_q  = vals[i];
        rfc_pkg::CFG_CRC_INIT: init_q  = vals[i];
        rfc_pkg::CFG_CMD_A:    cmd_a_q = vals[i][7:0];
        rfc_pkg::CFG_CMD_B:    cmd_b_q = vals[i][7:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_frames();
    send_new_frame(16'd3, FR_GOOD);
    send_byte(rfc_pkg::NAK_BYTE, 1'b1);
    build_body(16'd1, FR_GOOD);
    seal_frame(FR_GOOD);
    send_frame(2, 1'b1);
    send_new_frame(16'd0, FR_GOOD);
    send_new_frame(16'd2, FR_GOOD);
    send_new_frame(16'd5, FR_DEV_ERR);
    send_new_frame(16'd3, FR_DEV_ERR);
    send_new_frame(16'd4, FR_CMD_BAD);
    send_new_frame(16'd3, FR_CRC_BAD);
    // ACK and NAK inside a frame are plain data.
    build_body(16'd6, FR_GOOD);
    frame_bytes[7] = rfc_pkg::ACK_BYTE;
    frame_bytes[8] = rfc_pkg::NAK_BYTE;
    seal_frame(FR_GOOD);
    send_frame(0, 1'b0);
    // A frame start in the middle of a frame abandons it.
    build_body(16'd8, FR_GOOD);
    for (int i = 0; i < 4; i++) begin
      send_byte(frame_bytes[i], i == 0);
    end
    send_new_frame(16'd4, FR_GOOD);
    settle();
  endtask

  task automatic test_config_extremes();
    write_config(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_new_frame(16'd6, FR_GOOD);
    send_new_frame(16'd0, FR_GOOD);
    send_new_frame(16'd4, FR_DEV_ERR);
    send_new_frame(16'd5, FR_CRC_BAD);
    write_config(16'h0000, 16'h0000, 8'h00, 8'h00);
    send_new_frame(16'd6, FR_GOOD);
    send_new_frame(16'd3, FR_CMD_BAD);
    send_new_frame(16'd5, FR_CRC_BAD);
    write_config(16'h8005, 16'hA5A5, rfc_pkg::ERR_MARK, 8'h5A);
    send_new_frame(16'd7, FR_DEV_ERR);
    send_new_frame(16'd1, FR_GOOD);
    settle();
  endtask

  // A maximum length field is taken, then a new frame start abandons the frame.
  task automatic test_max_length_header();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    build_body(16'd60, FR_GOOD);
    frame_bytes[1] = 8'hFF;
    frame_bytes[2] = 8'hFF;
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i], i == 0);
    end
    send_new_frame(16'd3, FR_GOOD);
    settle();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    settle();
    tx_gaps_on = 1'b0;
    hold_left  = 300;
    for (int i = 0; i < 24; i++) begin
      send_byte(rfc_pkg::NAK_BYTE, 1'($urandom_range(0, 1)));
    end
    send_new_frame(16'd6, FR_GOOD);
    settle();
    tx_gaps_on = 1'b1;
  endtask

  task automatic random_reply();
    int          pick;
    int          len;
    int          cut;
    frame_kind_e kind;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        len = $urandom_range(0, 2);
      end else if (pick < 95) begin
        len = $urandom_range(3, 24);
      end else begin
        len = $urandom_range(25, 300);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        kind = FR_GOOD;
      end else if (pick < 60) begin
        kind = FR_DEV_ERR;
      end else if (pick < 75) begin
        kind = FR_CMD_BAD;
      end else begin
        kind = FR_CRC_BAD;
      end
      build_body(16'(len), kind);
      seal_frame(kind);
      send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0,
                 (pos_q != 0) ? 1'b1 : 1'($urandom_range(0, 1)));
    end else if (pick < 80) begin
      send_byte(rfc_pkg::NAK_BYTE, 1'($urandom_range(0, 1)));
    end else if (pick < 90) begin
      build_body(16'($urandom_range(3, 24)), FR_GOOD);
      seal_frame(FR_GOOD);
      cut = $urandom_range(1, frame_bytes.size() - 1);
      for (int i = 0; i < cut; i++) begin
        send_byte(frame_bytes[i], i == 0);
      end
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_replies();
    int goal;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_config(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
        1: write_config(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        2: write_config(16'h0000, 16'h0000, 8'h00, 8'h00);
        default: write_config(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      endcase
      tx_gaps_on   = (ph != 1);
      rx_stalls_on = (ph != 1);
      goal = reply_bytes_sent + RANDOM_BYTES / 4;
      while (reply_bytes_sent < goal) begin
        random_reply();
      end
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    settle();
  endtask

  always @(negedge clk) begin : report_check
    rfc_pkg::result_t r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected report, expected none, actual status %0d", $time, status);
      end else begin
        r = pending_reports.pop_front();
        compare_field("status", 17'(r.status), 17'(status));
        compare_field("frame_len", r.frame_len, frame_len);
        compare_field("dev_code_hi", 17'(r.dev_hi), 17'(dev_hi));
        compare_field("dev_code_lo", 17'(r.dev_lo), 17'(dev_lo));
      end
    end
  end

  initial begin : receiver
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
          stall_left = draw_gap();
        end
      end
    end
  end

  initial begin : watchdog
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : main
    rst_n       <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= rfc_pkg::CFG_CRC_POLY;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    rx_byte     <= '0;
    frame_start <= 1'b0;
    poly_q      = rfc_pkg::CRC_POLY_RST;
    init_q      = rfc_pkg::CRC_INIT_RST;
    cmd_a_q     = '0;
    cmd_b_q     = '0;
    pos_q       = '0;
    len_q       = '0;
    crc_q       = rfc_pkg::CRC_INIT_RST;
    crc_hi_q    = '0;
    echo_bad_q  = 1'b0;
    dev_err_q   = 1'b0;
    code_hi_q   = '0;
    code_lo_q   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_config_extremes();
    test_max_length_header();
    test_output_backpressure();
    test_random_replies();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/rfc_pkg.sv
hw/rtl/rfc_cfg_regs.sv
hw/rtl/rfc_frame_parser.sv
hw/rtl/response_frame_checker_unit.sv
test/tb.sv
